FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros for the RTL (used by lbp_ctrl).
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

FILE: rtl/lbp_pkg.sv
// ----------------------------------------------------------------------------
// lbp_pkg
// Shared types and constants of the LRU buffer pool.
// ----------------------------------------------------------------------------
package lbp_pkg;
  localparam int unsigned NumFramesDefault = 16;
  localparam logic [2:0] KIND_GET        = 3'd0;
  localparam logic [2:0] KIND_GET_PIN    = 3'd1;
  localparam logic [2:0] KIND_ANON       = 3'd2;
  localparam logic [2:0] KIND_ANON_PIN   = 3'd3;
  localparam logic [2:0] KIND_UNPIN      = 3'd4;
  localparam logic       REG_FRAMES      = 1'b0;
  localparam logic       REG_ANON_FILE   = 1'b1;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  file_id;
    logic [31:0] page_number;
    logic [3:0]  unpin_frame;
  } req_t;

  typedef struct packed {
    logic [3:0]  frame_index;
    logic        hit;
    logic        did_evict;
    logic [7:0]  evicted_file;
    logic [31:0] evicted_page;
    logic [31:0] assigned_page;
    logic        status;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture request, clear scan state
    logic scan;    // examine frame at scan index
    logic commit;  // apply update, build result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
  } sts_t;
endpackage

FILE: rtl/lbp_if.sv
// ----------------------------------------------------------------------------
// lbp_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface lbp_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/lbp_datapath.sv
// ----------------------------------------------------------------------------
// lbp_datapath
// Frame tables, one-frame-per-cycle lookup and victim scan, update logic.
// ----------------------------------------------------------------------------
module lbp_datapath import lbp_pkg::*; #(
  parameter int unsigned NUM_FRAMES = NumFramesDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  output sts_t       sts,
  input  req_t       req,
  input  logic [4:0] frames_in_use,
  input  logic [7:0] anon_file_id,
  output rsp_t       rsp
);
  localparam int IW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int CW = $clog2(NUM_FRAMES + 1);

  logic [NUM_FRAMES-1:0] frame_valid, frame_pinned;
  logic [7:0]  frame_file  [NUM_FRAMES];
  logic [31:0] frame_page  [NUM_FRAMES];
  logic [31:0] frame_stamp [NUM_FRAMES];
  logic [31:0] stamp_counter, anon_counter;
  logic [CW-1:0] fill_count;

  req_t r;
  logic [IW-1:0] idx;
  logic found, vic_ok;
  logic [IW-1:0] found_idx, vic_idx;
  logic [31:0] vic_stamp;

  // effective key of the held request
  logic anon, pin;
  logic [7:0] key_file;
  logic [31:0] key_page;
  assign anon = (r.kind == KIND_ANON) || (r.kind == KIND_ANON_PIN);
  assign pin  = (r.kind == KIND_GET_PIN) || (r.kind == KIND_ANON_PIN);
  assign key_file = anon ? anon_file_id : r.file_id;
  assign key_page = anon ? anon_counter + 32'd1 : r.page_number;

  assign sts.scan_last = (idx == IW'(NUM_FRAMES - 1));

  // fill limit clamped to 1..NUM_FRAMES
  logic [CW:0] lim;
  always_comb begin
    if (frames_in_use == 5'd0) lim = (CW+1)'(1);
    else if ({{CW{1'b0}}, frames_in_use} > (CW+5)'(NUM_FRAMES)) lim = (CW+1)'(NUM_FRAMES);
    else lim = (CW+1)'(frames_in_use);
  end

  // examine one frame per cycle
  logic cur_match, cur_cand;
  assign cur_match = frame_valid[idx] && frame_file[idx] == key_file
                     && frame_page[idx] == key_page && !anon;
  assign cur_cand = frame_valid[idx] && !frame_pinned[idx];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r      <= req;
      idx    <= '0;
      found  <= 1'b0;
      vic_ok <= 1'b0;
    end else if (cmd.scan) begin
      if (cur_match && !found) begin
        found     <= 1'b1;
        found_idx <= idx;
      end
      if (cur_cand && (!vic_ok || frame_stamp[idx] < vic_stamp)) begin
        vic_ok    <= 1'b1;
        vic_idx   <= idx;
        vic_stamp <= frame_stamp[idx];
      end
      if (!sts.scan_last) idx <= idx + IW'(1);
    end
  end

  // apply the request
  logic full;
  logic [IW-1:0] tgt;
  assign full = {1'b0, fill_count} >= lim;
  assign tgt = full ? vic_idx : fill_count[IW-1:0];

  // build the result beat
  rsp_t rsp_next;
  always_comb begin
    rsp_next = '0;
    if (r.kind == KIND_UNPIN) begin
      rsp_next.frame_index = r.unpin_frame;
    end else if (r.kind <= KIND_ANON_PIN) begin
      rsp_next.assigned_page = key_page;
      if (found) begin
        rsp_next.frame_index = 4'(found_idx);
        rsp_next.hit = 1'b1;
      end else if (full && !vic_ok) begin
        rsp_next.status = 1'b1;
      end else begin
        rsp_next.frame_index = 4'(tgt);
        if (full) begin
          rsp_next.did_evict    = 1'b1;
          rsp_next.evicted_file = frame_file[vic_idx];
          rsp_next.evicted_page = frame_page[vic_idx];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid   <= '0;
      frame_pinned  <= '0;
      stamp_counter <= '0;
      anon_counter  <= '0;
      fill_count    <= '0;
    end else if (cmd.commit) begin
      rsp <= rsp_next;
      if (r.kind == KIND_UNPIN) begin
        if ({28'd0, r.unpin_frame} < 32'(NUM_FRAMES))
          frame_pinned[IW'(r.unpin_frame)] <= 1'b0;
      end else if (r.kind <= KIND_ANON_PIN) begin
        if (found) begin
          stamp_counter <= stamp_counter + 32'd1;
          frame_stamp[found_idx] <= stamp_counter + 32'd1;
        end else if (!(full && !vic_ok)) begin
          if (!full) fill_count <= fill_count + CW'(1);
          if (anon) anon_counter <= anon_counter + 32'd1;
          frame_valid[tgt]  <= 1'b1;
          frame_pinned[tgt] <= pin;
          frame_file[tgt]   <= key_file;
          frame_page[tgt]   <= key_page;
          stamp_counter     <= stamp_counter + 32'd1;
          frame_stamp[tgt]  <= stamp_counter + 32'd1;
        end
      end
    end
  end
endmodule

FILE: rtl/lbp_ctrl.sv
// ----------------------------------------------------------------------------
// lbp_ctrl
// Sequencer: accept, scan all frames, commit, hold result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module lbp_ctrl import lbp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);
  localparam logic [1:0] S_IDLE = 2'd0, S_SCAN = 2'd1, S_COMMIT = 2'd2, S_OUT = 2'd3;
  logic [1:0] state, state_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign cmd.load   = in_ready && in_valid;
  assign cmd.scan   = (state == S_SCAN);
  assign cmd.commit = (state == S_COMMIT);

  // advance through the sequence
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_SCAN;
      S_SCAN:   if (sts.scan_last) state_next = S_COMMIT;
      S_COMMIT: state_next = S_OUT;
      S_OUT:    if (out_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  `ASSERT_NEXT(a_commit_out, clk, rst, cmd.commit, out_valid)
  `ASSERT_IMPLIES(a_no_accept_busy, clk, rst, out_valid, !in_ready)
  `ASSERT_NEXT(a_load_scan, clk, rst, cmd.load, cmd.scan)
endmodule

FILE: rtl/lru_buffer_pool_with_pins.sv
// Sequence: accept, scan of every frame, commit; the result is then held until
// taken. A new request is accepted only once the result of the last one has
// been taken, so requests do not overlap in the pool.
// Synchronous reset clears valid and pin marks, counters, and sets registers
// to 16 frames and anonymous file id 255.
// ----------------------------------------------------------------------------
// lru_buffer_pool_with_pins
// LRU buffer pool with pinning: top level with APB register port.
// ----------------------------------------------------------------------------
module lru_buffer_pool_with_pins import lbp_pkg::*; #(
  parameter int unsigned NUM_FRAMES = NumFramesDefault
) (
  input  logic        clk,
  input  logic        rst,
  lbp_if.sink         req,
  lbp_if.source       rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [4:0] frames_in_use;
  logic [7:0] anon_file_id;
  cmd_t cmd;
  sts_t sts;

  // register file
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= 5'd16;
      anon_file_id  <= 8'd255;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      unique case (paddr[2])
        REG_FRAMES:    frames_in_use <= pwdata[4:0];
        REG_ANON_FILE: anon_file_id  <= pwdata[7:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_FRAMES:    prdata = {27'd0, frames_in_use};
      REG_ANON_FILE: prdata = {24'd0, anon_file_id};
      default: ;
    endcase
  end

  lbp_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(req.valid), .in_ready(req.ready),
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .sts, .cmd
  );

  lbp_datapath #(.NUM_FRAMES(NUM_FRAMES)) u_dp (
    .clk, .rst, .cmd, .sts, .req(req.data),
    .frames_in_use, .anon_file_id, .rsp(rsp.data)
  );
endmodule

FILE: bench/lbp_checker.sv
// ----------------------------------------------------------------------------
// lbp_checker
// Watches the request and response channels of the LRU buffer pool, predicts
// each response from its own model of the frame table and compares.
// ----------------------------------------------------------------------------
module lbp_checker import lbp_pkg::*; #(
  parameter int unsigned NUM_FRAMES = NumFramesDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic       req_ready,
  input  req_t       req_data,
  input  logic       rsp_valid,
  input  logic       rsp_ready,
  input  rsp_t       rsp_data,
  input  logic       cfg_we,
  input  logic [2:0] cfg_addr,
  input  logic [31:0] cfg_data,
  output int         errors,
  output int         pending,
  output int         n_hits,
  output int         n_evicts,
  output int         n_full
);
  logic        fr_valid  [NUM_FRAMES];
  logic [7:0]  fr_file   [NUM_FRAMES];
  logic [31:0] fr_page   [NUM_FRAMES];
  logic        fr_pinned [NUM_FRAMES];
  logic [31:0] fr_stamp  [NUM_FRAMES];
  logic [31:0] stamp_cnt, anon_cnt;
  int unsigned fill_cnt;
  logic [4:0]  limit_reg;
  logic [7:0]  anon_file_reg;
  rsp_t        expected_rsp[$];

  assign pending = expected_rsp.size();

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // advance the frame table by one request and return its response
  function automatic rsp_t lookup_page(input req_t r);
    rsp_t o;
    int f, lim;
    logic pin, anon;
    logic [7:0] fid;
    logic [31:0] pg;
    o = '0;
    pin = (r.kind == KIND_GET_PIN) || (r.kind == KIND_ANON_PIN);
    anon = (r.kind == KIND_ANON) || (r.kind == KIND_ANON_PIN);
    fid = r.file_id;
    pg = r.page_number;
    f = -1;
    if (r.kind == KIND_UNPIN) begin
      if (r.unpin_frame < NUM_FRAMES) fr_pinned[r.unpin_frame] = 1'b0;
      o.frame_index = r.unpin_frame;
    end else if (r.kind <= KIND_ANON_PIN) begin
      if (anon) begin
        fid = anon_file_reg;
        pg = anon_cnt + 32'd1;
      end else begin
        for (int i = 0; i < NUM_FRAMES; i++)
          if (f < 0 && fr_valid[i] && fr_file[i] == fid && fr_page[i] == pg) f = i;
      end
      o.assigned_page = pg;
      if (f >= 0) begin
        stamp_cnt++;
        fr_stamp[f] = stamp_cnt;
        o.frame_index = 4'(f);
        o.hit = 1'b1;
      end else begin
        lim = int'(limit_reg);
        if (lim < 1) lim = 1;
        if (lim > NUM_FRAMES) lim = NUM_FRAMES;
        if (fill_cnt < lim) begin
          f = int'(fill_cnt);
          fill_cnt++;
        end else begin
          for (int i = 0; i < NUM_FRAMES; i++)
            if (fr_valid[i] && !fr_pinned[i] && (f < 0 || fr_stamp[i] < fr_stamp[f])) f = i;
          if (f >= 0) begin
            o.did_evict = 1'b1;
            o.evicted_file = fr_file[f];
            o.evicted_page = fr_page[f];
          end
        end
        if (f < 0) begin
          o.status = 1'b1;
        end else begin
          if (anon) anon_cnt++;
          fr_valid[f] = 1'b1;
          fr_file[f] = fid;
          fr_page[f] = pg;
          fr_pinned[f] = pin;
          stamp_cnt++;
          fr_stamp[f] = stamp_cnt;
          o.frame_index = 4'(f);
        end
      end
    end
    return o;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      for (int i = 0; i < NUM_FRAMES; i++) begin
        fr_valid[i] = 1'b0;
        fr_pinned[i] = 1'b0;
      end
      stamp_cnt = '0;
      anon_cnt = '0;
      fill_cnt = 0;
      limit_reg = 5'd16;
      anon_file_reg = 8'd255;
      expected_rsp.delete();
      errors = 0;
      n_hits = 0;
      n_evicts = 0;
      n_full = 0;
    end else begin
      // register writes
      if (cfg_we) begin
        if (cfg_addr[2] == REG_FRAMES) limit_reg = cfg_data[4:0];
        else anon_file_reg = cfg_data[7:0];
      end
      // check the response beat against the oldest prediction
      if (rsp_valid && rsp_ready) begin
        if (expected_rsp.size() == 0) begin
          report("unexpected beat", 32'(rsp_data.frame_index), 32'd0);
        end else begin
          want = expected_rsp.pop_front();
          if (rsp_data.frame_index !== want.frame_index)
            report("frame_index", 32'(rsp_data.frame_index), 32'(want.frame_index));
          if (rsp_data.hit !== want.hit)
            report("hit", 32'(rsp_data.hit), 32'(want.hit));
          if (rsp_data.did_evict !== want.did_evict)
            report("did_evict", 32'(rsp_data.did_evict), 32'(want.did_evict));
          if (rsp_data.evicted_file !== want.evicted_file)
            report("evicted_file", 32'(rsp_data.evicted_file), 32'(want.evicted_file));
          if (rsp_data.evicted_page !== want.evicted_page)
            report("evicted_page", rsp_data.evicted_page, want.evicted_page);
          if (rsp_data.assigned_page !== want.assigned_page)
            report("assigned_page", rsp_data.assigned_page, want.assigned_page);
          if (rsp_data.status !== want.status)
            report("status", 32'(rsp_data.status), 32'(want.status));
        end
      end
      // predict on each request beat
      if (req_valid && req_ready) begin
        want = lookup_page(req_data);
        if (want.hit) n_hits++;
        if (want.did_evict) n_evicts++;
        if (want.status) n_full++;
        expected_rsp.push_back(want);
      end
    end
  end
endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives page requests and register writes into the LRU buffer pool, with
// random stalls on both channels; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
  import lbp_pkg::*;

  localparam int NumItems = 1000;
  localparam int Latency = 40;
  localparam int CycleLimit = 400000;

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  logic        idle_src, idle_snk, hold_snk;
  int          errors, pending, n_hits, n_evicts, n_full;
  int          cycles, sent;

  lbp_if #(.payload_t(req_t)) req_ch ();
  lbp_if #(.payload_t(rsp_t)) rsp_ch ();

  lru_buffer_pool_with_pins dut (
    .clk(clk), .rst(rst), .req(req_ch.sink), .rsp(rsp_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  lbp_checker chk (
    .clk(clk), .rst(rst),
    .req_valid(req_ch.valid), .req_ready(req_ch.ready), .req_data(req_ch.data),
    .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready), .rsp_data(rsp_ch.data),
    .cfg_we(psel && penable && pwrite && pready), .cfg_addr(paddr), .cfg_data(pwdata),
    .errors(errors), .pending(pending), .n_hits(n_hits), .n_evicts(n_evicts),
    .n_full(n_full)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // abort on a hung run
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("timeout after %0d cycles", cycles);
        $display("** lru_buffer_pool_with_pins: FAILED **");
        $finish;
      end
    end
  end

  // response side: random stall bursts, or a long hold when asked
  initial begin
    int n;
    rsp_ch.ready <= 1'b0;
    idle_snk = 1'b1;
    hold_snk = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_snk) begin
        rsp_ch.ready <= 1'b0;
        repeat (200) @(posedge clk);
        hold_snk = 1'b0;
      end else if (idle_snk && $urandom_range(0, 3) == 0) begin
        rsp_ch.ready <= 1'b0;
        n = $urandom_range(1, 15);
        repeat (n) @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic cfg_write(input logic addr_sel, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {addr_sel, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // wait for every prediction to be answered, then for the block to settle
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (Latency) @(posedge clk);
  endtask

  // hold a request until accepted, with an optional random gap before it
  task automatic send_req(input logic [2:0] k, input logic [7:0] f, input logic [31:0] p,
                          input logic [3:0] u);
    int n;
    if (idle_src && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      n = $urandom_range(1, 15);
      repeat (n) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= '{kind: k, file_id: f, page_number: p, unpin_frame: u};
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sent++;
  endtask

  // random request biased to a small key set so hits and evictions recur
  task automatic send_random();
    logic [2:0] k;
    logic [7:0] f;
    logic [31:0] p;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) k = KIND_GET;
    else if (sel < 55) k = KIND_GET_PIN;
    else if (sel < 63) k = KIND_ANON;
    else if (sel < 68) k = KIND_ANON_PIN;
    else if (sel < 95) k = KIND_UNPIN;
    else k = 3'($urandom_range(5, 7));
    if ($urandom_range(0, 9) == 0) begin
      f = 8'($urandom);
      p = $urandom;
    end else begin
      f = 8'($urandom_range(0, 3));
      p = $urandom_range(0, 7);
      // sometimes name an anonymous page's key
      if ($urandom_range(0, 9) == 0) f = 8'hff;
    end
    send_req(k, f, p, 4'($urandom));
  endtask

  initial begin
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    req_ch.valid <= 1'b0;
    req_ch.data <= '0;
    idle_src = 1'b1;
    sent = 0;
    rst <= 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes, every kind, pool full of pinned frames
    cfg_write(REG_FRAMES, 32'd2);
    cfg_write(REG_ANON_FILE, 32'd0);
    send_req(KIND_GET, 8'h00, 32'h0, 4'h0);
    send_req(KIND_GET_PIN, 8'hff, 32'hffff_ffff, 4'hf);
    send_req(KIND_GET, 8'h00, 32'h0, 4'h0);
    send_req(KIND_GET, 8'h55, 32'haaaa_5555, 4'h5);
    send_req(KIND_GET_PIN, 8'haa, 32'h5555_aaaa, 4'ha);
    send_req(KIND_ANON, 8'h00, 32'h0, 4'h0);
    send_req(KIND_UNPIN, 8'h00, 32'h0, 4'hf);
    send_req(KIND_UNPIN, 8'h00, 32'h0, 4'h0);
    send_req(KIND_ANON_PIN, 8'h00, 32'h0, 4'h0);
    send_req(KIND_GET, 8'h00, 32'h1, 4'h0);
    send_req(KIND_GET, 8'h00, 32'h2, 4'h0);
    send_req(KIND_UNPIN, 8'h00, 32'h0, 4'h1);
    send_req(KIND_GET, 8'h00, 32'h2, 4'h0);
    send_req(3'd5, 8'hff, 32'hffff_ffff, 4'hf);
    send_req(3'd7, 8'h00, 32'h0, 4'h0);
    send_req(KIND_GET, 8'h00, 32'h1, 4'h0);
    drain();

    // random phases across several fill limits, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: cfg_write(REG_FRAMES, 32'd0);
        1: cfg_write(REG_FRAMES, 32'd16);
        2: cfg_write(REG_FRAMES, 32'd31);
        default: cfg_write(REG_FRAMES, 32'($urandom_range(1, 16)));
      endcase
      cfg_write(REG_ANON_FILE, ph == 1 ? 32'd255 : 32'($urandom_range(0, 255)));
      if (ph == 2) hold_snk = 1'b1;
      if (ph == 5) idle_src = 1'b0;
      if (ph == 5) idle_snk = 1'b0;
      for (int i = 0; i < NumItems / 6; i++) begin
        send_random();
        if (i == 80) drain();
      end
      drain();
    end

    $display("sent %0d requests: %0d hits, %0d evictions, %0d all-pinned refusals",
             sent, n_hits, n_evicts, n_full);
    if (errors == 0) $display("** lru_buffer_pool_with_pins: PASSED **");
    else $display("** lru_buffer_pool_with_pins: FAILED **");
    $finish;
  end
endmodule
